// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the page cache RTL.
// Both need a signal named clk in the including module; CDAPC_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CDAPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cdapc assertion failed");
`define CDAPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cdapc assertion failed");
`else
`define CDAPC_ASSERT(lbl, prop)
`define CDAPC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hdl/cdapc_pkg.sv -----
// Package for the clean/dirty adaptive page cache: sizes, entry layout,
// configuration register indexes and reset values. No dependencies.
package cdapc_pkg;
  localparam int MAX_ENTRIES = 64;
  localparam int PAGE_BITS   = 32;
  localparam int STAMP_W     = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int THR_W       = 6;
  localparam int LAT_W       = 16;
  localparam int CAP_W       = 7;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = CNT_W + LAT_W;
  localparam int NUM_W       = PROD_W + 2;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LAT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LAT = 2'd3;

  localparam logic [CAP_W-1:0] RST_CAPACITY  = 7'd64;
  localparam logic [THR_W-1:0] RST_INIT_THR  = 6'd32;
  localparam logic [LAT_W-1:0] RST_READ_LAT  = 16'd25;
  localparam logic [LAT_W-1:0] RST_WRITE_LAT = 16'd200;

  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 dirty;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;
endpackage

// ----- hdl/cdapc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the threshold step.
// Uses cdapc_pkg for operand width.
module cdapc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cdapc_pkg::NUM_W-1:0] num,
  input  logic [cdapc_pkg::NUM_W-1:0] den,
  output logic                        done,
  output logic [cdapc_pkg::NUM_W-1:0] quot
);
  localparam int NW = cdapc_pkg::NUM_W;
  localparam int CW = cdapc_pkg::DIV_CNT_W;

  logic [NW:0]   rem_r, rem_sh, rem_nxt;
  logic [NW-1:0] quo_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r, ge;

  always_comb begin
    rem_sh  = {rem_r[NW-1:0], quo_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule

// ----- hdl/clean_dirty_adaptive_page_cache.sv -----
// Clean/dirty adaptive page cache, top level. Uses cdapc_pkg, cdapc_div
// and assert_macros.svh.
//
// - cfg_we/cfg_index/cfg_data write capacity, initial threshold, read and
//   write latency; writing the initial threshold also reloads tau. Write
//   only while no request is in flight.
// - Input channel in_valid/in_stall carries in_cmd (0 write, 1 read) and
//   in_page_number. One request is worked on at a time.
// - Each request reads the 64-entry tag/stamp RAM one entry a cycle for the
//   page, the clean and dirty LRU entries and a free slot, then updates the
//   cache state and registers the result. A hit first adds two products and
//   a divide for tau.
// - in_stall drops at the edge that registers the result, so the next
//   request can be accepted at the following edge at the earliest. A result
//   still held by out_stall makes the update wait.
// - Output channel out_valid/out_stall holds the result fields until taken.
// - Reset (rst_n low, synchronous) marks all entries invalid at once,
//   clears counts and loads the register reset values.
`include "assert_macros.svh"
module clean_dirty_adaptive_page_cache (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cdapc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdapc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [cdapc_pkg::PAGE_BITS-1:0]     in_page_number,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic                                out_hit_in_dirty,
  output logic                                out_fetch,
  output logic                                out_evict_valid,
  output logic [cdapc_pkg::PAGE_BITS-1:0]     out_evict_page,
  output logic                                out_writeback,
  output logic [cdapc_pkg::THR_W-1:0]         out_threshold_now
);
  localparam int NE   = cdapc_pkg::MAX_ENTRIES;
  localparam int IW   = cdapc_pkg::IDX_W;
  localparam int CW   = cdapc_pkg::CNT_W;
  localparam int TW   = cdapc_pkg::THR_W;
  localparam int LW   = cdapc_pkg::LAT_W;
  localparam int PW   = cdapc_pkg::PROD_W;
  localparam int NW   = cdapc_pkg::NUM_W;
  localparam int SW   = cdapc_pkg::NUM_W + 1;
  localparam int STW  = cdapc_pkg::STAMP_W;
  localparam int PGW  = cdapc_pkg::PAGE_BITS;
  localparam int CPW  = cdapc_pkg::CAP_W;
  localparam int TMAX = (1 << TW) - 1;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_MUL, ST_DST, ST_DIV, ST_UPD} state_t;

  state_t state_r;

  // configuration
  logic [CPW-1:0] cap_r;
  logic [LW-1:0]  rlat_r, wlat_r;

  // cache state
  cdapc_pkg::entry_t mem [NE];
  cdapc_pkg::entry_t rd_q;
  logic [NE-1:0]  valid_r;
  logic [STW-1:0] use_cnt_r;
  logic [CW-1:0]  clean_r, dirty_r;
  logic [TW-1:0]  thr_r;

  // current request and scan results
  logic           cmd_r;
  logic [PGW-1:0] page_r;
  logic [CW-1:0]  scan_cnt_r;
  logic           issue_r;
  logic [IW-1:0]  issue_addr_r;
  logic           hit_f_r, hit_dirty_r;
  logic [IW-1:0]  hit_idx_r;
  logic           cl_f_r, dt_f_r, free_f_r;
  logic [IW-1:0]  cl_idx_r, dt_idx_r, free_idx_r;
  logic [STW-1:0] cl_age_r, dt_age_r;
  logic [PGW-1:0] cl_page_r, dt_page_r;
  logic [PW-1:0]  nw_r, dr_r;
  logic [NW-1:0]  q_r;

  // output register
  logic           out_valid_r, o_hit_r, o_hd_r, o_fetch_r, o_ev_r, o_wb_r;
  logic [PGW-1:0] o_evp_r;
  logic [TW-1:0]  o_thr_r;

  // combinational
  logic           in_acc, out_free, cur_vld, match, last_issue;
  logic [STW-1:0] age;
  logic [CW-1:0]  num_cnt, den_cnt;
  logic [LW-1:0]  rlat_eff;
  logic [CW-1:0]  cap_eff;
  logic           div_start, div_done;
  logic [NW-1:0]  div_num, div_den, div_quot;
  logic [SW-1:0]  t_sum;
  logic [TW-1:0]  thr_nxt;
  logic [CW-1:0]  clean_nxt, dirty_nxt;
  logic [NE-1:0]  valid_nxt;
  logic           full, ev, ev_dirty, ins;
  logic [IW-1:0]  v_idx, slot;
  logic [PGW-1:0] ev_page;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  cdapc_pkg::entry_t mem_wdata;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign rlat_eff = (rlat_r == '0) ? LW'(1) : rlat_r;
  always_comb begin
    if (cap_r < CPW'(2))       cap_eff = CW'(2);
    else if (cap_r > CPW'(NE)) cap_eff = CW'(NE);
    else                       cap_eff = CW'(cap_r);
  end

  // scan compare, one entry per cycle
  assign cur_vld    = valid_r[issue_addr_r];
  assign age        = use_cnt_r - rd_q.stamp;
  assign match      = issue_r && cur_vld && (rd_q.page == page_r);
  assign last_issue = issue_r && (issue_addr_r == IW'(NE - 1));

  assign num_cnt = hit_dirty_r ? clean_r : dirty_r;
  assign den_cnt = hit_dirty_r ? dirty_r : clean_r;
  assign div_num = NW'({nw_r, 1'b0}) + NW'(dr_r);
  assign div_den = NW'({dr_r, 1'b0});
  assign div_start = (state_r == ST_DST);

  cdapc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // update of the hit or miss
  always_comb begin
    thr_nxt   = thr_r;
    clean_nxt = clean_r;
    dirty_nxt = dirty_r;
    valid_nxt = valid_r;
    full      = 1'b0;
    ev        = 1'b0;
    ev_dirty  = 1'b0;
    ins       = 1'b0;
    v_idx     = cl_idx_r;
    slot      = free_idx_r;
    ev_page   = '0;
    mem_we    = 1'b0;
    mem_waddr = hit_idx_r;
    mem_wdata.page  = page_r;
    mem_wdata.dirty = (cmd_r != cdapc_pkg::CMD_READ);
    mem_wdata.stamp = use_cnt_r;
    t_sum     = SW'(thr_r) + SW'(q_r);
    if (hit_f_r) begin
      if (!hit_dirty_r) begin
        if (t_sum >= SW'(cap_eff)) t_sum = SW'(cap_eff) - SW'(1);
        if (t_sum > SW'(TMAX))     t_sum = SW'(TMAX);
        if (t_sum == '0)           t_sum = SW'(1);
        thr_nxt = t_sum[TW-1:0];
        if (cmd_r != cdapc_pkg::CMD_READ) begin
          if (clean_r != '0) clean_nxt = clean_r - 1'b1;
          dirty_nxt = dirty_r + 1'b1;
        end
      end else begin
        if (q_r >= NW'(thr_r)) thr_nxt = TW'(1);
        else                   thr_nxt = thr_r - q_r[TW-1:0];
      end
      mem_we          = 1'b1;
      mem_wdata.dirty = hit_dirty_r || (cmd_r != cdapc_pkg::CMD_READ);
    end else begin
      full = ({1'b0, clean_r} + {1'b0, dirty_r}) >= {1'b0, cap_eff};
      if (full) begin
        if (clean_r >= CW'(thr_r) || !dt_f_r) begin
          ev      = cl_f_r;
          v_idx   = cl_idx_r;
          ev_page = cl_page_r;
        end else begin
          ev       = 1'b1;
          ev_dirty = 1'b1;
          v_idx    = dt_idx_r;
          ev_page  = dt_page_r;
        end
      end
      if (!ev) ev_page = '0;
      if (ev) begin
        valid_nxt[v_idx] = 1'b0;
        if (ev_dirty) begin
          if (dirty_nxt != '0) dirty_nxt = dirty_nxt - 1'b1;
        end else begin
          if (clean_nxt != '0) clean_nxt = clean_nxt - 1'b1;
        end
      end
      // lowest free index after the eviction
      if (free_f_r && (!ev || free_idx_r < v_idx)) begin
        ins  = 1'b1;
        slot = free_idx_r;
      end else if (ev) begin
        ins  = 1'b1;
        slot = v_idx;
      end
      if (ins) begin
        valid_nxt[slot] = 1'b1;
        if (cmd_r == cdapc_pkg::CMD_READ) clean_nxt = clean_nxt + 1'b1;
        else                              dirty_nxt = dirty_nxt + 1'b1;
        mem_we    = 1'b1;
        mem_waddr = slot;
      end
    end
  end

  // tag/stamp RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we && state_r == ST_UPD && out_free) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[scan_cnt_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= cdapc_pkg::RST_CAPACITY;
      rlat_r      <= cdapc_pkg::RST_READ_LAT;
      wlat_r      <= cdapc_pkg::RST_WRITE_LAT;
      valid_r     <= '0;
      use_cnt_r   <= '0;
      clean_r     <= '0;
      dirty_r     <= '0;
      thr_r       <= cdapc_pkg::RST_INIT_THR;
      issue_r     <= 1'b0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cdapc_pkg::CFG_CAPACITY:  cap_r <= cfg_data[CPW-1:0];
          cdapc_pkg::CFG_INIT_THR: begin
            thr_r <= (cfg_data[TW-1:0] == '0) ? TW'(1) : cfg_data[TW-1:0];
          end
          cdapc_pkg::CFG_READ_LAT:  rlat_r <= cfg_data[LW-1:0];
          cdapc_pkg::CFG_WRITE_LAT: wlat_r <= cfg_data[LW-1:0];
          default: ;
        endcase
      end

      // in ST_UPD a taken result is replaced by the new one below
      if (out_valid_r && !out_stall && state_r != ST_UPD) out_valid_r <= 1'b0;

      issue_r <= (state_r == ST_SCAN) && (scan_cnt_r < CW'(NE));
      issue_addr_r <= scan_cnt_r[IW-1:0];

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r      <= in_cmd;
            page_r     <= in_page_number;
            scan_cnt_r <= '0;
            hit_f_r    <= 1'b0;
            cl_f_r     <= 1'b0;
            dt_f_r     <= 1'b0;
            free_f_r   <= 1'b0;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_issue) scan_cnt_r <= '0;
          else if (scan_cnt_r < CW'(NE)) scan_cnt_r <= scan_cnt_r + 1'b1;
          if (issue_r) begin
            if (match && !hit_f_r) begin
              hit_f_r     <= 1'b1;
              hit_idx_r   <= issue_addr_r;
              hit_dirty_r <= rd_q.dirty;
            end
            if (cur_vld && !rd_q.dirty && (!cl_f_r || age > cl_age_r)) begin
              cl_f_r    <= 1'b1;
              cl_idx_r  <= issue_addr_r;
              cl_age_r  <= age;
              cl_page_r <= rd_q.page;
            end
            if (cur_vld && rd_q.dirty && (!dt_f_r || age > dt_age_r)) begin
              dt_f_r    <= 1'b1;
              dt_idx_r  <= issue_addr_r;
              dt_age_r  <= age;
              dt_page_r <= rd_q.page;
            end
            if (!cur_vld && !free_f_r) begin
              free_f_r   <= 1'b1;
              free_idx_r <= issue_addr_r;
            end
          end
          if (last_issue) begin
            state_r    <= (hit_f_r || match) ? ST_MUL : ST_UPD;
          end
        end
        ST_MUL: begin
          nw_r    <= PW'(num_cnt) * PW'(wlat_r);
          dr_r    <= PW'(den_cnt) * PW'(rlat_eff);
          state_r <= ST_DST;
        end
        ST_DST: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            q_r     <= (div_den == '0) ? '0 : div_quot;
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            thr_r       <= thr_nxt;
            clean_r     <= clean_nxt;
            dirty_r     <= dirty_nxt;
            valid_r     <= valid_nxt;
            if (mem_we) use_cnt_r <= use_cnt_r + 1'b1;
            out_valid_r <= 1'b1;
            o_hit_r     <= hit_f_r;
            o_hd_r      <= hit_f_r && hit_dirty_r;
            o_fetch_r   <= !hit_f_r;
            o_ev_r      <= ev;
            o_evp_r     <= ev_page;
            o_wb_r      <= ev && ev_dirty;
            o_thr_r     <= thr_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = o_hit_r;
  assign out_hit_in_dirty  = o_hd_r;
  assign out_fetch         = o_fetch_r;
  assign out_evict_valid   = o_ev_r;
  assign out_evict_page    = o_evp_r;
  assign out_writeback     = o_wb_r;
  assign out_threshold_now = o_thr_r;

  `CDAPC_ASSERT(a_count_match, (32'(clean_r) + 32'(dirty_r)) == $countones(valid_r))
  `CDAPC_ASSERT(a_thr_nonzero, thr_r != '0)
  `CDAPC_ASSERT(a_result_from_upd, $rose(out_valid_r) |-> $past(state_r == ST_UPD))
endmodule

// ----- verif/clean_dirty_adaptive_page_cache_test.sv -----
// Self-checking testbench for clean_dirty_adaptive_page_cache: random and directed
// page requests, predicted in-bench against a behavioral cache model.
// Depends on cdapc_pkg and the DUT RTL only.
`timescale 1ns / 100ps
module clean_dirty_adaptive_page_cache_test;

  typedef struct {
    logic                            cmd;
    logic [cdapc_pkg::PAGE_BITS-1:0] page;
  } request_t;

  typedef struct {
    logic                            hit;
    logic                            hit_in_dirty;
    logic                            fetch;
    logic                            evict_valid;
    logic [cdapc_pkg::PAGE_BITS-1:0] evict_page;
    logic                            writeback;
    logic [cdapc_pkg::THR_W-1:0]     threshold_now;
  } outcome_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [cdapc_pkg::CFG_IDX_W-1:0] cfg_index = cdapc_pkg::CFG_CAPACITY;
  logic [cdapc_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_cmd = 1'b0;
  logic [cdapc_pkg::PAGE_BITS-1:0] in_page_number = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_hit, out_hit_in_dirty, out_fetch;
  logic                            out_evict_valid, out_writeback;
  logic [cdapc_pkg::PAGE_BITS-1:0] out_evict_page;
  logic [cdapc_pkg::THR_W-1:0]     out_threshold_now;

  clean_dirty_adaptive_page_cache dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  bit       req_taken = 1'b0;
  int       cycle = 0;
  int       fail_count = 0;
  int       hold_cnt = 0;

  // cache shadow state
  logic [cdapc_pkg::PAGE_BITS-1:0] sh_page [cdapc_pkg::MAX_ENTRIES];
  bit                   sh_valid[cdapc_pkg::MAX_ENTRIES];
  bit                   sh_dirty[cdapc_pkg::MAX_ENTRIES];
  logic [31:0]          sh_stamp[cdapc_pkg::MAX_ENTRIES];
  logic [31:0]          use_ctr;
  int                   clean_n, dirty_n, tau;
  int                   capacity_reg, init_thr_reg, rd_lat_reg, wr_lat_reg;

  function automatic longint cost_ratio(longint num_cnt, longint den_cnt);
    longint r;
    longint den;
    r = (rd_lat_reg == 0) ? 1 : rd_lat_reg;
    den = 2 * den_cnt * r;
    if (den == 0) return 0;
    return (2 * num_cnt * wr_lat_reg + den_cnt * r) / den;
  endfunction

  function automatic int oldest_entry(bit dirty);
    int          best;
    logic [31:0] best_age, age;
    best = -1;
    best_age = 0;
    for (int i = 0; i < cdapc_pkg::MAX_ENTRIES; i++) begin
      if (sh_valid[i] && sh_dirty[i] == dirty) begin
        age = use_ctr - sh_stamp[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic void load_tau();
    tau = (init_thr_reg < 1) ? 1 : init_thr_reg;
  endfunction

  function automatic void reset_shadow();
    capacity_reg = cdapc_pkg::RST_CAPACITY;
    init_thr_reg = cdapc_pkg::RST_INIT_THR;
    rd_lat_reg = cdapc_pkg::RST_READ_LAT;
    wr_lat_reg = cdapc_pkg::RST_WRITE_LAT;
    for (int i = 0; i < cdapc_pkg::MAX_ENTRIES; i++) sh_valid[i] = 1'b0;
    use_ctr = '0;
    clean_n = 0;
    dirty_n = 0;
    load_tau();
  endfunction

  function automatic outcome_t access_cache(request_t rq);
    outcome_t o;
    int       cap, found, victim, slot;
    longint   t, adj;
    bit       is_read;
    o = '{default: '0};
    is_read = (rq.cmd == cdapc_pkg::CMD_READ);
    cap = capacity_reg < 2 ? 2 : (capacity_reg > cdapc_pkg::MAX_ENTRIES ?
                                  cdapc_pkg::MAX_ENTRIES : capacity_reg);
    found = -1;
    for (int i = 0; i < cdapc_pkg::MAX_ENTRIES; i++)
      if (found < 0 && sh_valid[i] && sh_page[i] == rq.page) found = i;
    if (found >= 0) begin
      o.hit = 1'b1;
      if (!sh_dirty[found]) begin
        t = tau + cost_ratio(dirty_n, clean_n);
        if (t >= cap) t = cap - 1;
        if (t > 63) t = 63;
        if (t < 1) t = 1;
        tau = int'(t);
        if (!is_read) begin
          sh_dirty[found] = 1'b1;
          if (clean_n > 0) clean_n--;
          dirty_n++;
        end
      end else begin
        o.hit_in_dirty = 1'b1;
        adj = cost_ratio(clean_n, dirty_n);
        if (adj >= tau) tau = 1;
        else tau = tau - int'(adj);
      end
      sh_stamp[found] = use_ctr;
      use_ctr++;
    end else begin
      o.fetch = 1'b1;
      if (clean_n + dirty_n >= cap) begin
        if (clean_n >= tau) victim = oldest_entry(1'b0);
        else begin
          victim = oldest_entry(1'b1);
          if (victim < 0) victim = oldest_entry(1'b0);
        end
        if (victim >= 0) begin
          o.evict_valid = 1'b1;
          o.evict_page = sh_page[victim];
          if (sh_dirty[victim]) begin
            o.writeback = 1'b1;
            if (dirty_n > 0) dirty_n--;
          end else if (clean_n > 0) clean_n--;
          sh_valid[victim] = 1'b0;
        end
      end
      slot = -1;
      for (int i = 0; i < cdapc_pkg::MAX_ENTRIES; i++)
        if (slot < 0 && !sh_valid[i]) slot = i;
      if (slot >= 0) begin
        sh_valid[slot] = 1'b1;
        sh_page[slot] = rq.page;
        sh_dirty[slot] = !is_read;
        if (is_read) clean_n++;
        else dirty_n++;
        sh_stamp[slot] = use_ctr;
        use_ctr++;
      end
    end
    o.threshold_now = tau[cdapc_pkg::THR_W-1:0];
    return o;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (in_valid && !req_taken) begin
      // hold the offered request
    end else if (rst_n && pending_reqs.size() > 0 &&
                 ((cycle > 20000 && cycle < 30000) || $urandom_range(99) >= 10)) begin
      in_valid <= 1'b1;
      in_cmd <= pending_reqs[0].cmd;
      in_page_number <= pending_reqs[0].page;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result-side backpressure, with one long hold-off window
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (cycle == 3000) begin
      out_stall <= 1'b1;
      hold_cnt <= 399;
    end else if (cycle > 20000 && cycle < 30000) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    cycle <= cycle + 1;
    if (cycle > 1000000) begin
      $display("*** FAILED ***");
      $finish;
    end
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_outcomes.push_back(access_cache(pending_reqs[0]));
      void'(pending_reqs.pop_front());
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result");
        fail_count++;
      end else begin
        e = expected_outcomes.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit exp %0d got %0d", e.hit, out_hit); fail_count++;
        end
        if (out_hit_in_dirty !== e.hit_in_dirty) begin
          $error("hit_in_dirty exp %0d got %0d", e.hit_in_dirty, out_hit_in_dirty);
          fail_count++;
        end
        if (out_fetch !== e.fetch) begin
          $error("fetch exp %0d got %0d", e.fetch, out_fetch); fail_count++;
        end
        if (out_evict_valid !== e.evict_valid) begin
          $error("evict_valid exp %0d got %0d", e.evict_valid, out_evict_valid);
          fail_count++;
        end
        if (out_evict_page !== e.evict_page) begin
          $error("evict_page exp %h got %h", e.evict_page, out_evict_page); fail_count++;
        end
        if (out_writeback !== e.writeback) begin
          $error("writeback exp %0d got %0d", e.writeback, out_writeback); fail_count++;
        end
        if (out_threshold_now !== e.threshold_now) begin
          $error("threshold_now exp %0d got %0d", e.threshold_now, out_threshold_now);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [cdapc_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[cdapc_pkg::CFG_W-1:0];
    case (idx)
      cdapc_pkg::CFG_CAPACITY:  capacity_reg = value & 8'h7f;
      cdapc_pkg::CFG_INIT_THR:  begin init_thr_reg = value & 8'h3f; load_tau(); end
      cdapc_pkg::CFG_READ_LAT:  rd_lat_reg = value & 16'hffff;
      cdapc_pkg::CFG_WRITE_LAT: wr_lat_reg = value & 16'hffff;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_req(logic cmd, logic [cdapc_pkg::PAGE_BITS-1:0] page);
    request_t r;
    r.cmd = cmd;
    r.page = page;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_outcomes.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  // random accesses over a small page set so hits and evictions are common
  task automatic random_burst(int count, int cap);
    logic [cdapc_pkg::PAGE_BITS-1:0] base;
    base = $urandom;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) push_req(1'($urandom_range(1)), $urandom);
      else push_req(1'($urandom_range(1)), base + $urandom_range(2 * cap));
    end
  endtask

  initial begin
    int caps[6];
    int thrs[6];
    int rlats[6];
    int wlats[6];
    caps  = '{4, 2, 127, 1, 16, 0};
    thrs  = '{2, 0, 63, 1, 8, 40};
    rlats = '{25, 0, 65535, 1, 100, 3};
    wlats = '{200, 65535, 1, 1, 300, 7};
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, hit/miss on each list, extreme pages
    push_req(1'b0, 32'h0000_0000);
    push_req(1'b1, 32'h0000_0000);
    push_req(1'b1, 32'hffff_ffff);
    push_req(1'b1, 32'hffff_ffff);
    push_req(1'b0, 32'hffff_ffff);
    push_req(1'b1, 32'h5555_5555);
    push_req(1'b0, 32'haaaa_aaaa);
    push_req(1'b1, 32'h5555_5555);
    push_req(1'b0, 32'haaaa_aaaa);
    drain();

    // tiny cache: clean and dirty evictions, lowered capacity below occupancy
    write_reg(cdapc_pkg::CFG_CAPACITY, 2);
    write_reg(cdapc_pkg::CFG_INIT_THR, 1);
    for (int i = 0; i < 4; i++) push_req(i[0], 32'h100 + i);
    push_req(1'b1, 32'h102);
    push_req(1'b1, 32'h103);
    push_req(1'b0, 32'h103);
    push_req(1'b1, 32'h104);
    push_req(1'b1, 32'h105);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(cdapc_pkg::CFG_CAPACITY, caps[p]);
      write_reg(cdapc_pkg::CFG_INIT_THR, thrs[p]);
      write_reg(cdapc_pkg::CFG_READ_LAT, rlats[p]);
      write_reg(cdapc_pkg::CFG_WRITE_LAT, wlats[p]);
      random_burst(100, (caps[p] < 2) ? 2 : (caps[p] > 64 ? 64 : caps[p]));
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
